>>> sv/scpr_pkg.sv
// Shared types and constants for the second-chance page replacement block.
// No dependencies; imported by the top level.
package scpr_pkg;

  // Fixed field widths of the stream items.
  localparam int FRAME_W   = 6;
  localparam int PROC_W    = 4;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int TDATA_W   = 16;
  localparam int FRAME_IDS = 64;
  localparam int ENTRY_W   = FRAME_W + PROC_W;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REF     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPLACE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // One queue entry as held in the queue memory.
  typedef struct packed {
    logic [PROC_W-1:0]  owner;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_DONE
  } state_t;

endpackage

>>> sv/scpr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the frame queue of the replacement block.
module scpr_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/second_chance_page_replacement.sv
// Second-chance page replacement: a circular queue of FRAMES frame entries in one RAM,
// a referenced bit per frame number in flip-flops, and a small sequencer.
// Depends on scpr_pkg and scpr_ram.
//
// Allocate, reference and unused kinds go from the accept through the execute and done
// states into the output register. A replace examines one queue entry per cycle through the
// single RAM read port, rotating referenced entries to the tail as it goes; it examines at
// most the queue occupancy plus one entries in the check state before the done state. The
// block accepts one item at a time; its result sits in an output register and the next item
// is taken while that result waits, but a finished item holds the sequencer until the output
// register is free.
module second_chance_page_replacement
  import scpr_pkg::*;
#(
  parameter int FRAMES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [TDATA_W-1:0]  s_tdata,   // [5:0] frame_number, [9:6] process_id
  input  logic [KIND_W-1:0]   s_tuser,   // [1:0] kind
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [TDATA_W-1:0]  m_tdata,   // [5:0] victim_frame, [9:6] victim_process
  output logic [STATUS_W-1:0] m_tuser    // [1:0] status
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int SUM_W = CNT_W + 1;

  state_t state, state_next;

  logic [IDX_W-1:0]     head, head_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [FRAME_IDS-1:0] ref_bits, ref_bits_next;

  logic [KIND_W-1:0]    item_kind;
  logic [FRAME_W-1:0]   item_frame;
  logic [PROC_W-1:0]    item_pid;

  logic [STATUS_W-1:0]  res_status, res_status_next;
  logic [FRAME_W-1:0]   res_frame, res_frame_next;
  logic [PROC_W-1:0]    res_proc, res_proc_next;

  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [FRAME_W-1:0]   out_frame;
  logic [PROC_W-1:0]    out_proc;

  logic                 wr_en, rd_en;
  logic [IDX_W-1:0]     wr_addr, rd_addr;
  logic [ENTRY_W-1:0]   wr_data, rd_data;
  entry_t               rd_entry;
  logic                 ref_hit;
  logic                 in_accept, out_load;

  // Queue slot arithmetic: base plus offset stays below twice FRAMES.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(FRAMES)) begin
      sum = sum - SUM_W'(FRAMES);
    end
    return sum[IDX_W-1:0];
  endfunction

  scpr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FRAMES)
  ) u_queue (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_entry  = entry_t'(rd_data);
  assign ref_hit   = ref_bits[rd_entry.frame];
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_load  = (state == ST_DONE) && (!out_valid || m_tready);

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (item_kind == KIND_REPLACE && count != '0) begin
          state_next = ST_CHECK;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_CHECK: begin
        if (!ref_hit || count == CNT_W'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath control: queue accesses, pointers, referenced bits and result.
  always_comb begin
    head_next       = head;
    count_next      = count;
    ref_bits_next   = ref_bits;
    res_status_next = res_status;
    res_frame_next  = res_frame;
    res_proc_next   = res_proc;
    wr_en           = 1'b0;
    wr_addr         = wrap_add(head, count);
    wr_data         = rd_data;
    rd_en           = 1'b0;
    rd_addr         = head;
    case (state)
      ST_EXEC: begin
        res_status_next = STATUS_OK;
        res_frame_next  = '0;
        res_proc_next   = '0;
        case (item_kind)
          KIND_ALLOC: begin
            if (count == CNT_W'(FRAMES)) begin
              res_status_next = STATUS_FULL;
            end else begin
              wr_en                     = 1'b1;
              wr_data                   = {item_pid, item_frame};
              ref_bits_next[item_frame] = 1'b0;
              count_next                = count + CNT_W'(1);
            end
          end
          KIND_REF: begin
            ref_bits_next[item_frame] = 1'b1;
          end
          KIND_REPLACE: begin
            if (count == '0) begin
              res_status_next = STATUS_EMPTY;
            end else begin
              rd_en = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ST_CHECK: begin
        if (!ref_hit) begin
          // Unreferenced head entry is the victim.
          res_frame_next = rd_entry.frame;
          res_proc_next  = rd_entry.owner;
          head_next      = wrap_add(head, CNT_W'(1));
          count_next     = count - CNT_W'(1);
        end else if (count == CNT_W'(1)) begin
          // A lone referenced entry rotates onto itself and is then evicted.
          ref_bits_next[rd_entry.frame] = 1'b0;
          res_frame_next = rd_entry.frame;
          res_proc_next  = rd_entry.owner;
          head_next      = wrap_add(head, CNT_W'(2));
          count_next     = '0;
        end else begin
          // Second chance: clear the bit, move the entry to the tail, read the next head.
          ref_bits_next[rd_entry.frame] = 1'b0;
          wr_en     = 1'b1;
          rd_en     = 1'b1;
          rd_addr   = wrap_add(head, CNT_W'(1));
          head_next = wrap_add(head, CNT_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      count    <= '0;
      ref_bits <= '0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      count    <= count_next;
      ref_bits <= ref_bits_next;
    end
  end

  // Item capture and working result.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_kind  <= s_tuser;
      item_frame <= s_tdata[FRAME_W-1:0];
      item_pid   <= s_tdata[FRAME_W+PROC_W-1:FRAME_W];
    end
    res_status <= res_status_next;
    res_frame  <= res_frame_next;
    res_proc   <= res_proc_next;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_frame  <= res_frame;
      out_proc   <= res_proc;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {{(TDATA_W - FRAME_W - PROC_W){1'b0}}, out_proc, out_frame};

  // The queue never holds more entries than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FRAMES))
    else $error("queue occupancy exceeds depth");

  // An accepted item is decoded in the following cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == ST_EXEC)
    else $error("accepted item not decoded");

  // The victim scan only runs over a non-empty queue.
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> count != '0)
    else $error("victim scan on empty queue");

  // A new result only appears after the sequencer finished an item.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result without finished item");

  // Error results carry no victim.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != STATUS_OK |-> m_tdata == '0)
    else $error("error result carries a victim");

endmodule
